FILE: hdl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared constants and types for the running median tracker: store size,
// sample widths, the link passed between neighboring cells and the insert
// controls broadcast along the chain.
// ----------------------------------------------------------------------------
package rmt_pkg;

  localparam int CAPACITY    = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int MED_BITS    = SAMPLE_BITS + 1;
  localparam int CNT_BITS    = $clog2(CAPACITY + 1);

  // Cells per reduction group and number of groups (last group padded if short)
  localparam int GROUP  = 32;
  localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

  // What one cell shows its right-hand neighbor and the median taps
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;  // held sample
    logic                   vld;  // cell holds a kept sample
    logic                   gt;   // held sample is greater than the new one
    logic                   lo;   // lower middle position
    logic                   hi;   // upper middle position
  } link_t;

  // Insert controls, common to all cells
  typedef struct packed {
    logic ins;     // keep the incoming sample
    logic lo_adv;  // move lower middle mark one cell right
    logic hi_adv;  // move upper middle mark one cell right
  } ctl_t;

endpackage

FILE: hdl/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell
// One position of the sorted insertion chain. On an insert, a cell whose
// sample is greater than the new one takes its left neighbor's sample (or the
// new sample if the neighbor is not greater); the first empty cell is filled
// the same way. The middle marks shift right on their own advance strobes.
// ----------------------------------------------------------------------------
module rmt_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  rmt_pkg::ctl_t                  ctl,
  input  logic [rmt_pkg::SAMPLE_BITS-1:0] sample,
  input  rmt_pkg::link_t                 left,
  output rmt_pkg::link_t                 right
);
  import rmt_pkg::*;

  logic [SAMPLE_BITS-1:0] val;
  logic                   vld;
  logic                   lo;
  logic                   hi;
  logic                   gt;
  logic                   take;

  // Compare against the broadcast sample and decide whether to load
  assign gt   = vld && ($signed(val) > $signed(sample));
  assign take = gt || (!vld && left.vld);

  // Load shifted or new sample
  always_ff @(posedge clk) begin
    if (ctl.ins && take) begin
      val <= left.gt ? left.val : sample;
    end
  end

  // Occupancy and middle marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      lo  <= 1'b0;
      hi  <= 1'b0;
    end else begin
      if (ctl.ins && take) begin
        vld <= 1'b1;
      end
      if (ctl.lo_adv) begin
        lo <= left.lo;
      end
      if (ctl.hi_adv) begin
        hi <= left.hi;
      end
    end
  end

  assign right = '{val: val, vld: vld, gt: gt, lo: lo, hi: hi};

endmodule

FILE: hdl/rmt_tap_reduce.sv
// ----------------------------------------------------------------------------
// rmt_tap_reduce
// Picks the marked samples out of one group of cells. Each middle mark is
// one-hot over the chain, so an AND-OR over the group gives the marked value
// or zero; the result is registered.
// ----------------------------------------------------------------------------
module rmt_tap_reduce (
  input  logic                            clk,
  input  logic                            adv,
  input  rmt_pkg::link_t                  lnk [rmt_pkg::GROUP],
  output logic [rmt_pkg::SAMPLE_BITS-1:0] lo_val,
  output logic [rmt_pkg::SAMPLE_BITS-1:0] hi_val
);
  import rmt_pkg::*;

  logic [SAMPLE_BITS-1:0] lo_or;
  logic [SAMPLE_BITS-1:0] hi_or;

  // Merge marked samples of the group
  always_comb begin
    lo_or = '0;
    hi_or = '0;
    for (int i = 0; i < GROUP; i++) begin
      lo_or = lo_or | (lnk[i].val & {SAMPLE_BITS{lnk[i].lo}});
      hi_or = hi_or | (lnk[i].val & {SAMPLE_BITS{lnk[i].hi}});
    end
  end

  // Hold while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      lo_val <= lo_or;
      hi_val <= hi_or;
    end
  end

endmodule

FILE: hdl/running_median_tracker_core.sv
// ----------------------------------------------------------------------------
// running_median_tracker_core
// Running median over all samples kept since reset, in a sorted cell chain.
// ----------------------------------------------------------------------------
// Accepts one sample per clock while the result side is not stalled and
// presents one result per sample after the chain, group and output registers.
// The chain sorts a new sample into place as all cells load at once; two
// marks that travel in the chain flag the lower and upper middle cells, and a
// two-level AND-OR tree (registered groups of 32 cells, then across groups)
// reads them out before the final full-width sum. median_doubled is twice the
// median (one fractional bit). Once 1024 samples are kept, further samples are
// not stored and come back with dropped set. Reset empties the store.
// ----------------------------------------------------------------------------
module running_median_tracker_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rmt_pkg::SAMPLE_BITS-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rmt_pkg::MED_BITS-1:0]    median_doubled,
  output logic [rmt_pkg::CNT_BITS-1:0]    sample_count,
  output logic                            dropped
);
  import rmt_pkg::*;

  logic                   adv;
  logic                   accept;
  logic                   not_full;
  ctl_t                   ctl;
  logic [CNT_BITS-1:0]    count;

  // Pipeline stage after insert, and after group reduction
  logic                   v0;
  logic [CNT_BITS-1:0]    c0;
  logic                   d0;
  logic                   v1;
  logic [CNT_BITS-1:0]    c1;
  logic                   d1;

  link_t                  chain [CAPACITY+1];
  link_t                  taps  [NGROUP][GROUP];
  logic [SAMPLE_BITS-1:0] grp_lo [NGROUP];
  logic [SAMPLE_BITS-1:0] grp_hi [NGROUP];
  logic [SAMPLE_BITS-1:0] lo_all;
  logic [SAMPLE_BITS-1:0] hi_all;

  // Advance everything when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign not_full = count < CNT_BITS'(CAPACITY);

  // Insert controls; both marks enter the chain with the first sample
  assign ctl.ins    = accept && not_full;
  assign ctl.lo_adv = ctl.ins && !count[0];
  assign ctl.hi_adv = ctl.ins && (count[0] || (count == '0));

  // Virtual cell to the left of the first one
  assign chain[0] = '{val: '0, vld: 1'b1, gt: 1'b0,
                      lo: (count == '0), hi: (count == '0)};

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rmt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (sample),
      .left   (chain[i]),
      .right  (chain[i+1])
    );
  end

  // Arrange cells into groups, padding the last one with empty links
  for (genvar i = 0; i < NGROUP * GROUP; i++) begin : g_tap
    if (i < CAPACITY) begin : g_real
      assign taps[i / GROUP][i % GROUP] = chain[i+1];
    end else begin : g_pad
      assign taps[i / GROUP][i % GROUP] = '0;
    end
  end

  // First reduction level
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    rmt_tap_reduce u_reduce (
      .clk    (clk),
      .adv    (adv),
      .lnk    (taps[g]),
      .lo_val (grp_lo[g]),
      .hi_val (grp_hi[g])
    );
  end

  // Second reduction level across groups
  always_comb begin
    lo_all = '0;
    hi_all = '0;
    for (int g = 0; g < NGROUP; g++) begin
      lo_all = lo_all | grp_lo[g];
      hi_all = hi_all | grp_hi[g];
    end
  end

  // Control: kept count and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.ins) begin
        count <= count + CNT_BITS'(1);
      end
      if (adv) begin
        v0        <= accept;
        v1        <= v0;
        out_valid <= v1;
      end
    end
  end

  // Payload: count and drop flag follow their item; form the full-width sum
  always_ff @(posedge clk) begin
    if (adv) begin
      c0             <= not_full ? count + CNT_BITS'(1) : count;
      d0             <= !not_full;
      c1             <= c0;
      d1             <= d0;
      sample_count   <= c1;
      dropped        <= d1;
      median_doubled <= {lo_all[SAMPLE_BITS-1], lo_all} +
                        {hi_all[SAMPLE_BITS-1], hi_all};
    end
  end

endmodule

FILE: hdl/rmt_checker.sv
// ----------------------------------------------------------------------------
// rmt_checker
// Port-level checks for the running median tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rmt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [rmt_pkg::SAMPLE_BITS-1:0] sample,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rmt_pkg::MED_BITS-1:0]    median_doubled,
  input logic [rmt_pkg::CNT_BITS-1:0]    sample_count,
  input logic                            dropped
);
  import rmt_pkg::*;

  // Input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A dropped sample only happens with the store full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> (sample_count == CNT_BITS'(CAPACITY)))
    else $error("sample dropped while store not full");

  // Odd count: median is a kept sample, doubled value is even
  a_odd_even: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sample_count[0]) |-> !median_doubled[0])
    else $error("odd count gave odd doubled median");

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(median_doubled) &&
                                  $stable(sample_count) && $stable(dropped)))
    else $error("stalled result changed");

endmodule

bind running_median_tracker_core rmt_checker u_rmt_checker (.*);

FILE: dv/running_median_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// running_median_tracker_core_tb
// Self-checking bench for the running median tracker. Samples are pushed
// through the valid/stall input port, and a sorted shadow store predicts
// twice the median, the kept count and the dropped flag for every transfer.
// It runs a directed set of extreme and duplicate samples, then random
// samples under three idle/stall mixes, enough to overflow the store.
// ----------------------------------------------------------------------------
module running_median_tracker_core_tb;
  import rmt_pkg::*;

  localparam int QUIET_LIMIT   = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES  = 12;    // wait for stray results before the verdict
  localparam int RANDOM_ITEMS  = 410;   // random samples per idle/stall mix
  localparam int DIRECTED_ITEMS = 20;

  typedef struct {
    logic [MED_BITS-1:0] median_doubled;
    logic [CNT_BITS-1:0] sample_count;
    logic                dropped;
  } median_result_t;

  // Sorted shadow store and queue of predicted medians
  class median_scoreboard;
    longint              sorted_store[CAPACITY];
    int unsigned         kept_total;
    median_result_t      pending_medians[$];
    int unsigned         mismatches;

    // Insert an accepted sample and predict its result
    function void note_sample(logic [SAMPLE_BITS-1:0] value);
      longint         s;
      longint         twice_med;
      int unsigned    pos;
      int unsigned    mid;
      median_result_t r;
      s = longint'($signed(value));
      r.dropped = 1'b1;
      if (kept_total < CAPACITY) begin
        // shift larger samples up; equal ones stay below the new sample
        pos = kept_total;
        while (pos > 0 && sorted_store[pos-1] > s) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos] = s;
        kept_total++;
        r.dropped = 1'b0;
      end
      mid = kept_total / 2;
      if (kept_total % 2)
        twice_med = sorted_store[mid] + sorted_store[mid];
      else
        twice_med = sorted_store[mid-1] + sorted_store[mid];
      r.median_doubled = twice_med[MED_BITS-1:0];
      r.sample_count   = kept_total[CNT_BITS-1:0];
      pending_medians.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(logic [MED_BITS-1:0] med, logic [CNT_BITS-1:0] cnt,
                               logic drp);
      median_result_t e;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: med=%0d cnt=%0d drop=%0b", $signed(med), cnt, drp);
        return;
      end
      e = pending_medians.pop_front();
      if (med !== e.median_doubled || cnt !== e.sample_count || drp !== e.dropped) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"median mismatch: expected med=%0d cnt=%0d drop=%0b, ",
                    "got med=%0d cnt=%0d drop=%0b"},
                   $signed(e.median_doubled), e.sample_count, e.dropped,
                   $signed(med), cnt, drp);
      end
    endfunction

    function int unsigned pending();
      return pending_medians.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MED_BITS-1:0]    median_doubled;
  logic [CNT_BITS-1:0]    sample_count;
  logic                   dropped;

  median_scoreboard       sb;
  int                     snd_idle_pct = 12;
  int                     rcv_stall_pct = 62;
  int                     quiet_cycles = 0;

  running_median_tracker_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_doubled (median_doubled),
    .sample_count   (sample_count),
    .dropped        (dropped)
  );

  always #5 clk = ~clk;

  // Check result transfers and pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(median_doubled, sample_count, dropped);
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // Give up when nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one sample, idling cycle by cycle first, and hold it until transfer
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(value);
  endtask

  // Mix of full-range, clustered, extreme and scaled samples
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned            kind;
    logic [SAMPLE_BITS-1:0] v;
    kind = $urandom_range(99);
    if (kind < 40) begin
      v = $urandom;
    end else if (kind < 60) begin
      v = int'($urandom_range(16)) - 8;
    end else if (kind < 70) begin
      case ($urandom_range(5))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = 32'h7FFF_FFFE;
        3:       v = 32'h8000_0001;
        4:       v = 32'hFFFF_FFFF;
        default: v = 32'h0000_0000;
      endcase
    end else if (kind < 85) begin
      v = int'($urandom_range(131071)) - 65536;
    end else begin
      v = $urandom >> $urandom_range(31);
      if ($urandom_range(1))
        v = -v;
    end
    return v;
  endfunction

  // Wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  logic [SAMPLE_BITS-1:0] directed_samples [DIRECTED_ITEMS] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF,                // top of range, doubled and summed
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h8000_0000,                               // bottom pair in the middle
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
    32'h0000_0005, 32'h0000_0005, 32'h0000_0005, // runs of equal samples
    32'h8000_0001, 32'h7FFF_FFFE,
    32'h5555_5555, 32'hAAAA_AAAA,
    32'h7FFF_0000, 32'h8000_FFFF,
    32'h0000_0005, 32'hFFFF_FFFB
  };

  initial begin
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed samples under the first idle/stall mix
    foreach (directed_samples[i])
      send_sample(directed_samples[i]);
    wait_drained();

    // random samples: sender light/receiver heavy, then swapped, then none
    for (int mix = 0; mix < 3; mix++) begin
      snd_idle_pct  = (mix == 0) ? 12 : (mix == 1) ? 62 : 0;
      rcv_stall_pct = (mix == 0) ? 62 : (mix == 1) ? 12 : 0;
      repeat (RANDOM_ITEMS) send_sample(pick_sample());
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
